// ===== design/hep_pkg.sv =====
// ----------------------------------------------------------------------------
// hep_pkg
// Shared types and constants for the Heston Euler path step block.
// ----------------------------------------------------------------------------
`default_nettype none

package hep_pkg;

  // Fixed-point word format: signed Q16.16 in a 32-bit word.
  localparam int DATA_W = 32;
  localparam int FRAC_W = 16;

  // Square root works on x * 2^FRAC_W, with x below 2^(DATA_W-1).
  localparam int SQRT_W = (DATA_W - 1 + FRAC_W + 1) / 2;
  localparam int RAD_W  = 2 * SQRT_W;

  // Saturation limits of the word.
  localparam logic signed [DATA_W-1:0] WORD_MAX = {1'b0, {(DATA_W-1){1'b1}}};
  localparam logic signed [DATA_W-1:0] WORD_MIN = {1'b1, {(DATA_W-1){1'b0}}};

  // Configuration register indexes.
  localparam logic [3:0] REG_REVERSION = 4'd0;
  localparam logic [3:0] REG_LONG_VAR  = 4'd1;
  localparam logic [3:0] REG_VOL_VAR   = 4'd2;
  localparam logic [3:0] REG_DRIFT     = 4'd3;
  localparam logic [3:0] REG_INIT_VAR  = 4'd4;
  localparam logic [3:0] REG_INIT_PRC  = 4'd5;
  localparam logic [3:0] REG_PATH_LEN  = 4'd6;
  localparam logic [3:0] REG_MODE      = 4'd7;

  // Diffusion modes.
  localparam logic MODE_MULT = 1'b0;

  // Operations of the shared arithmetic unit.
  typedef enum logic [1:0] {
    OP_MUL,
    OP_ADD,
    OP_SUB,
    OP_ABS
  } alu_op_t;

endpackage

`default_nettype wire

// ===== design/heston_euler_path_step.sv =====
// ----------------------------------------------------------------------------
// heston_euler_path_step
// One Euler step of a Heston-type Monte Carlo path per input item, computed
// by a small sequencer around one shared saturating arithmetic unit and an
// iterative square root unit.
// ----------------------------------------------------------------------------
//
// Channel   Direction  Handshake              Payload
// s_*       in         s_tvalid / s_tready    s_tdata: dt, dWv, dWs
// m_*       out        m_tvalid / m_tready    m_tdata: v', S'; m_tlast: path done
// cfg_*     in         cfg_valid / cfg_ready  cfg_index, cfg_data
//
// Each item makes 16 passes through the shared unit and two square roots (each a
// start, 24 bit steps and a done strobe), then waits in the output state. Items
// are accepted only in idle, so a new item enters only after the last one has
// been loaded into the output register. The square root unit takes most of the time.
// Reset is synchronous and restores the configuration registers to their defaults
// and the path state to the default initial variance and price. A stalled output holds
// its result; the next item is accepted as soon as the sequencer is back in idle.
// ----------------------------------------------------------------------------
`default_nettype none

module heston_euler_path_step (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [87:0] s_tdata,   // time_increment[16:0], variance_noise[48:17],
                                 // price_noise[80:49], zeros[87:81]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [63:0] m_tdata,   // variance_out[30:0], price_out[62:31], zero[63]
  output logic        m_tlast,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [3:0]  cfg_index,
  input  logic [31:0] cfg_data
);
  import hep_pkg::*;

  typedef enum logic [4:0] {
    ST_IDLE, ST_D_SUB, ST_D_A, ST_D_DT, ST_X_V, ST_SQ1_GO, ST_SQ1_WAIT,
    ST_S_NU, ST_S_WV, ST_VN_D, ST_VN_S, ST_VN_ABS, ST_X_VN, ST_SQ2_GO,
    ST_SQ2_WAIT, ST_G_WS, ST_G_P, ST_T_MU, ST_T_DT, ST_P_T, ST_P_G, ST_OUT
  } state_t;

  state_t state;

  // Configuration registers.
  logic [30:0]              rev_rate;
  logic [30:0]              long_var;
  logic [30:0]              vol_var;
  logic signed [DATA_W-1:0] drift;
  logic [30:0]              init_var;
  logic signed [DATA_W-1:0] init_price;
  logic [15:0]              path_len;
  logic                     mode;

  // Path state and working registers.
  logic signed [DATA_W-1:0] var_now;
  logic signed [DATA_W-1:0] price_now;
  logic [15:0]              step_cnt;
  logic [16:0]              dt;
  logic signed [DATA_W-1:0] wv;
  logic signed [DATA_W-1:0] ws;
  logic signed [DATA_W-1:0] d_acc;
  logic signed [DATA_W-1:0] s_acc;
  logic signed [DATA_W-1:0] vn;
  logic signed [DATA_W-1:0] g_acc;
  logic signed [DATA_W-1:0] t_acc;

  alu_op_t                  alu_op;
  logic signed [DATA_W-1:0] alu_a;
  logic signed [DATA_W-1:0] alu_b;
  logic signed [DATA_W-1:0] alu_res;

  logic                     sq_start;
  logic                     sq_busy;
  logic                     sq_done;
  logic [SQRT_W-1:0]        sq_root;
  logic signed [DATA_W-1:0] sq_word;

  logic signed [DATA_W-1:0] dt_word;
  logic                     last_step;
  logic                     out_free;

  assign dt_word   = DATA_W'({1'b0, dt});
  assign sq_word   = DATA_W'({1'b0, sq_root});
  assign last_step = ({1'b0, step_cnt} + 17'd1) >= {1'b0, path_len};
  assign out_free  = !m_tvalid || m_tready;
  assign s_tready  = (state == ST_IDLE);
  assign cfg_ready = 1'b1;
  assign sq_start  = (state == ST_SQ1_GO) || (state == ST_SQ2_GO);

  // Operand selection for the shared unit, one operation per state.
  always_comb begin
    alu_op = OP_MUL;
    alu_a  = d_acc;
    alu_b  = dt_word;
    case (state)
      ST_D_SUB:  begin alu_op = OP_SUB; alu_a = DATA_W'({1'b0, long_var}); alu_b = var_now; end
      ST_D_A:    begin alu_a = d_acc; alu_b = DATA_W'({1'b0, rev_rate}); end
      ST_D_DT:   begin alu_a = d_acc; alu_b = dt_word; end
      ST_X_V:    begin alu_a = var_now; alu_b = dt_word; end
      ST_S_NU:   begin alu_a = sq_word; alu_b = DATA_W'({1'b0, vol_var}); end
      ST_S_WV:   begin alu_a = s_acc; alu_b = wv; end
      ST_VN_D:   begin alu_op = OP_ADD; alu_a = var_now; alu_b = d_acc; end
      ST_VN_S:   begin alu_op = OP_ADD; alu_a = vn; alu_b = s_acc; end
      ST_VN_ABS: begin alu_op = OP_ABS; alu_a = vn; alu_b = vn; end
      ST_X_VN:   begin alu_a = vn; alu_b = dt_word; end
      ST_G_WS:   begin alu_a = sq_word; alu_b = ws; end
      ST_G_P:    begin alu_a = price_now; alu_b = g_acc; end
      ST_T_MU:   begin alu_a = price_now; alu_b = drift; end
      ST_T_DT:   begin alu_a = t_acc; alu_b = dt_word; end
      ST_P_T:    begin alu_op = OP_ADD; alu_a = price_now; alu_b = t_acc; end
      ST_P_G:    begin alu_op = OP_ADD; alu_a = t_acc; alu_b = g_acc; end
      default:   begin alu_op = OP_MUL; alu_a = d_acc; alu_b = dt_word; end
    endcase
  end

  hep_alu u_alu (
    .op  (alu_op),
    .opa (alu_a),
    .opb (alu_b),
    .res (alu_res)
  );

  hep_sqrt u_sqrt (
    .clk   (clk),
    .rst   (rst),
    .start (sq_start),
    .x     (d_acc),
    .busy  (sq_busy),
    .done  (sq_done),
    .root  (sq_root)
  );

  // Sequencer, configuration, path state and output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      m_tvalid   <= 1'b0;
      rev_rate   <= 31'd65536;
      long_var   <= 31'd2621;
      vol_var    <= 31'd19661;
      drift      <= 32'sd3277;
      init_var   <= 31'd2621;
      init_price <= 32'sd6553600;
      path_len   <= 16'd256;
      mode       <= MODE_MULT;
      var_now    <= 32'sd2621;
      price_now  <= 32'sd6553600;
      step_cnt   <= '0;
    end else begin
      // The output state loads a new item itself whenever the old one leaves.
      if (m_tvalid && m_tready && state != ST_OUT) begin
        m_tvalid <= 1'b0;
      end
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_REVERSION: rev_rate   <= cfg_data[30:0];
          REG_LONG_VAR:  long_var   <= cfg_data[30:0];
          REG_VOL_VAR:   vol_var    <= cfg_data[30:0];
          REG_DRIFT:     drift      <= cfg_data;
          REG_INIT_VAR:  init_var   <= cfg_data[30:0];
          REG_INIT_PRC:  init_price <= cfg_data;
          REG_PATH_LEN:  path_len   <= cfg_data[15:0];
          REG_MODE:      mode       <= cfg_data[0];
          default:       ;
        endcase
      end
      case (state)
        ST_IDLE: begin
          if (s_tvalid) begin
            dt    <= s_tdata[16:0];
            wv    <= s_tdata[48:17];
            ws    <= s_tdata[80:49];
            state <= ST_D_SUB;
          end
        end
        ST_D_SUB:  begin d_acc <= alu_res; state <= ST_D_A; end
        ST_D_A:    begin d_acc <= alu_res; state <= ST_D_DT; end
        ST_D_DT:   begin s_acc <= alu_res; state <= ST_X_V; end
        // The radicand goes through d_acc; the finished d term moves from s_acc to vn.
        ST_X_V:    begin d_acc <= alu_res; vn <= s_acc; state <= ST_SQ1_GO; end
        ST_SQ1_GO: state <= ST_SQ1_WAIT;
        ST_SQ1_WAIT: begin
          if (sq_done) begin
            state <= ST_S_NU;
          end
        end
        ST_S_NU:   begin s_acc <= alu_res; state <= ST_S_WV; end
        ST_S_WV:   begin s_acc <= alu_res; d_acc <= vn; state <= ST_VN_D; end
        ST_VN_D:   begin vn <= alu_res; state <= ST_VN_S; end
        ST_VN_S:   begin vn <= alu_res; state <= ST_VN_ABS; end
        ST_VN_ABS: begin vn <= alu_res; state <= ST_X_VN; end
        ST_X_VN:   begin d_acc <= alu_res; state <= ST_SQ2_GO; end
        ST_SQ2_GO: state <= ST_SQ2_WAIT;
        ST_SQ2_WAIT: begin
          if (sq_done) begin
            state <= ST_G_WS;
          end
        end
        ST_G_WS:   begin g_acc <= alu_res; state <= ST_G_P; end
        ST_G_P: begin
          if (mode == MODE_MULT) begin
            g_acc <= alu_res;
          end
          state <= ST_T_MU;
        end
        ST_T_MU:   begin t_acc <= alu_res; state <= ST_T_DT; end
        ST_T_DT:   begin t_acc <= alu_res; state <= ST_P_T; end
        ST_P_T:    begin t_acc <= alu_res; state <= ST_P_G; end
        ST_P_G:    begin t_acc <= alu_res; state <= ST_OUT; end
        ST_OUT: begin
          if (out_free) begin
            m_tvalid <= 1'b1;
            m_tdata  <= {1'b0, t_acc, vn[30:0]};
            m_tlast  <= last_step;
            if (last_step) begin
              var_now   <= DATA_W'({1'b0, init_var});
              price_now <= init_price;
              step_cnt  <= '0;
            end else begin
              var_now   <= vn;
              price_now <= t_acc;
              step_cnt  <= step_cnt + 16'd1;
            end
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // The variance state is never negative.
  a_var_nonneg: assert property (@(posedge clk) disable iff (rst)
    !var_now[DATA_W-1]) else $error("variance state went negative");

  // The square root unit is idle whenever a new item may enter.
  a_sqrt_idle: assert property (@(posedge clk) disable iff (rst)
    s_tready |-> !sq_busy) else $error("square root busy while idle");

  // A finished path restarts its step count.
  a_path_restart: assert property (@(posedge clk) disable iff (rst)
    (state == ST_OUT && out_free && last_step) |=> (step_cnt == 16'd0))
    else $error("step count not cleared at path end");

  // A square root completes only while the sequencer waits for it.
  a_sqrt_wait: assert property (@(posedge clk) disable iff (rst)
    sq_done |-> (state == ST_SQ1_WAIT || state == ST_SQ2_WAIT))
    else $error("square root finished outside a wait state");

endmodule

`default_nettype wire

// ===== design/hep_alu.sv =====
// ----------------------------------------------------------------------------
// hep_alu
// Shared saturating fixed-point unit: floor multiply, add, subtract, abs.
// ----------------------------------------------------------------------------
`default_nettype none

module hep_alu (
  input  hep_pkg::alu_op_t                     op,
  input  logic signed [hep_pkg::DATA_W-1:0]    opa,
  input  logic signed [hep_pkg::DATA_W-1:0]    opb,
  output logic signed [hep_pkg::DATA_W-1:0]    res
);
  import hep_pkg::*;

  logic signed [2*DATA_W-1:0]        prod;
  logic signed [2*DATA_W-FRAC_W-1:0] prod_sh;
  logic signed [DATA_W-1:0]          neg_b;
  logic signed [DATA_W-1:0]          add_b;
  logic signed [DATA_W:0]            sum;
  logic signed [DATA_W-1:0]          mul_sat;
  logic signed [DATA_W-1:0]          sum_sat;

  // Product shifted right arithmetically, which floors toward minus infinity.
  assign prod    = opa * opb;
  assign prod_sh = prod[2*DATA_W-1:FRAC_W];

  always_comb begin
    if (prod_sh > $signed({{(DATA_W-FRAC_W){1'b0}}, WORD_MAX})) begin
      mul_sat = WORD_MAX;
    end else if (prod_sh < $signed({{(DATA_W-FRAC_W){1'b1}}, WORD_MIN})) begin
      mul_sat = WORD_MIN;
    end else begin
      mul_sat = prod_sh[DATA_W-1:0];
    end
  end

  // Saturating negation of the second operand for subtract.
  assign neg_b = (opb == WORD_MIN) ? WORD_MAX : -opb;
  assign add_b = (op == OP_SUB) ? neg_b : opb;
  assign sum   = {opa[DATA_W-1], opa} + {add_b[DATA_W-1], add_b};

  always_comb begin
    if (sum[DATA_W] != sum[DATA_W-1]) begin
      sum_sat = sum[DATA_W] ? WORD_MIN : WORD_MAX;
    end else begin
      sum_sat = sum[DATA_W-1:0];
    end
  end

  // Result selection.
  always_comb begin
    case (op)
      OP_MUL:  res = mul_sat;
      OP_ADD:  res = sum_sat;
      OP_SUB:  res = sum_sat;
      OP_ABS:  res = !opa[DATA_W-1] ? opa : ((opa == WORD_MIN) ? WORD_MAX : -opa);
      default: res = mul_sat;
    endcase
  end

endmodule

`default_nettype wire

// ===== design/hep_sqrt.sv =====
// ----------------------------------------------------------------------------
// hep_sqrt
// Iterative floored square root of x * 2^FRAC_W, one result bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module hep_sqrt (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               start,
  input  logic signed [hep_pkg::DATA_W-1:0]  x,
  output logic                               busy,
  output logic                               done,
  output logic [hep_pkg::SQRT_W-1:0]         root
);
  import hep_pkg::*;

  localparam int CNT_W = $clog2(SQRT_W);
  localparam logic [CNT_W-1:0] LAST_STEP = CNT_W'(SQRT_W - 1);

  logic [RAD_W-1:0]   rad;
  logic [SQRT_W+1:0]  rem;
  logic [CNT_W-1:0]   cnt;
  logic [SQRT_W+3:0]  rem_sh;
  logic [SQRT_W+3:0]  trial;
  logic [SQRT_W+3:0]  rem_diff;
  logic               take;
  logic [SQRT_W+1:0]  rem_next;
  logic [SQRT_W-1:0]  root_next;

  // One restoring step: bring down two radicand bits and try the next bit.
  assign rem_sh    = {rem, rad[RAD_W-1 -: 2]};
  assign trial     = {2'b00, root, 2'b01};
  assign take      = (rem_sh >= trial);
  assign rem_diff  = rem_sh - trial;
  assign rem_next  = take ? rem_diff[SQRT_W+1:0] : rem_sh[SQRT_W+1:0];
  assign root_next = {root[SQRT_W-2:0], take};

  // Sequencing of the bit steps.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == LAST_STEP) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // Datapath; a radicand that is not positive yields zero.
  always_ff @(posedge clk) begin
    if (start) begin
      rem  <= '0;
      root <= '0;
      if (x > 0) begin
        rad <= RAD_W'({x[DATA_W-2:0], {FRAC_W{1'b0}}});
      end else begin
        rad <= '0;
      end
    end else if (busy) begin
      rem  <= rem_next;
      root <= root_next;
      rad  <= {rad[RAD_W-3:0], 2'b00};
    end
  end

endmodule

`default_nettype wire

// ===== tb/sv/heston_euler_path_step_checker.sv =====
// ----------------------------------------------------------------------------
// heston_euler_path_step_checker
// Watches the configuration, input and output channels of the Heston Euler
// path step block, predicts every result from its own copy of the registers
// and path state, and compares each result field by field.
// ----------------------------------------------------------------------------
`default_nettype none

module heston_euler_path_step_checker
  import hep_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  input  logic        s_tready,
  input  logic [87:0] s_tdata,
  input  logic        m_tvalid,
  input  logic        m_tready,
  input  logic [63:0] m_tdata,
  input  logic        m_tlast,
  input  logic        cfg_valid,
  input  logic        cfg_ready,
  input  logic [3:0]  cfg_index,
  input  logic [31:0] cfg_data,
  output int          fail_count,
  output int          pending_steps
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [30:0] variance;
    logic [31:0] price;
    logic        done;
  } step_result_t;

  localparam longint QMAX = 64'sd2147483647;
  localparam longint QMIN = -64'sd2147483648;

  // Register copies and path state.
  logic [31:0] regs [8];
  longint      var_now;
  longint      price_now;
  int unsigned step_count;

  step_result_t expected_steps[$];

  assign pending_steps = expected_steps.size();

  function automatic longint clamp(longint x);
    if (x > QMAX) return QMAX;
    if (x < QMIN) return QMIN;
    return x;
  endfunction

  // Q16.16 multiply: floor of the exact product, then saturated.
  function automatic longint qmul(longint x, longint y);
    logic signed [127:0] p;
    p = $signed(128'(x)) * $signed(128'(y));
    p = p >>> FRAC_W;
    if (p > QMAX) return QMAX;
    if (p < QMIN) return QMIN;
    return longint'(p);
  endfunction

  function automatic longint qadd(longint x, longint y);
    return clamp(x + y);
  endfunction

  function automatic longint qneg(longint x);
    return clamp(-x);
  endfunction

  // Floored square root of x * 2^16; nonpositive input gives zero.
  function automatic longint qsqrt(longint x);
    logic [63:0] n;
    logic [63:0] r;
    logic [63:0] c;
    if (x <= 0) return 0;
    n = 64'(x) << FRAC_W;
    r = 0;
    for (int i = 31; i >= 0; i--) begin
      c = r | (64'd1 << i);
      if (c * c <= n) r = c;
    end
    return clamp(longint'(r));
  endfunction

  function automatic longint ureg(int i);
    return longint'({33'd0, regs[i][30:0]});
  endfunction

  task automatic reset_model();
    regs[REG_REVERSION] = 32'd65536;
    regs[REG_LONG_VAR]  = 32'd2621;
    regs[REG_VOL_VAR]   = 32'd19661;
    regs[REG_DRIFT]     = 32'd3277;
    regs[REG_INIT_VAR]  = 32'd2621;
    regs[REG_INIT_PRC]  = 32'd6553600;
    regs[REG_PATH_LEN]  = 32'd256;
    regs[REG_MODE]      = 32'd0;
    var_now   = ureg(REG_INIT_VAR);
    price_now = longint'($signed(regs[REG_INIT_PRC]));
    step_count = 0;
  endtask

  // One Euler step of the path, returning the expected output item.
  function automatic step_result_t advance_path(logic [87:0] data);
    longint dt, wv, ws, d, s, vn, g, pn, v, p;
    logic last;
    step_result_t r;
    dt = longint'(data[16:0]);
    wv = longint'($signed(data[48:17]));
    ws = longint'($signed(data[80:49]));
    v  = var_now;
    p  = price_now;
    d  = qmul(qmul(qadd(ureg(REG_LONG_VAR), qneg(v)), ureg(REG_REVERSION)), dt);
    s  = qmul(qmul(qsqrt(qmul(v, dt)), ureg(REG_VOL_VAR)), wv);
    vn = qadd(qadd(v, d), s);
    if (vn < 0) vn = qneg(vn);
    g = qmul(qsqrt(qmul(vn, dt)), ws);
    if (regs[REG_MODE][0] == MODE_MULT) g = qmul(p, g);
    pn = qadd(qadd(p, qmul(qmul(p, longint'($signed(regs[REG_DRIFT]))), dt)), g);
    last = (step_count + 1) >= regs[REG_PATH_LEN][15:0];
    if (last) begin
      var_now   = ureg(REG_INIT_VAR);
      price_now = longint'($signed(regs[REG_INIT_PRC]));
      step_count = 0;
    end else begin
      var_now   = vn;
      price_now = pn;
      step_count = (step_count + 1) & 16'hFFFF;
    end
    r.variance = vn[30:0];
    r.price    = pn[31:0];
    r.done     = last;
    return r;
  endfunction

  initial begin
    fail_count = 0;
    reset_model();
  end

  // Track every channel at the clock edge.
  always @(posedge clk) begin
    step_result_t want;
    if (rst) begin
      reset_model();
      expected_steps.delete();
    end else begin
      if (cfg_valid && cfg_ready && cfg_index < 8) begin
        case (cfg_index)
          REG_DRIFT, REG_INIT_PRC: begin
            regs[cfg_index] = cfg_data;
          end
          REG_PATH_LEN: begin
            regs[cfg_index] = {16'd0, cfg_data[15:0]};
          end
          REG_MODE: begin
            regs[cfg_index] = {31'd0, cfg_data[0]};
          end
          default: begin
            regs[cfg_index] = {1'b0, cfg_data[30:0]};
          end
        endcase
      end
      if (s_tvalid && s_tready) expected_steps.push_back(advance_path(s_tdata));
      if (m_tvalid && m_tready) begin
        if (expected_steps.size() == 0) begin
          $error("unexpected output item: variance_out=%0d price_out=%0d",
                 m_tdata[30:0], $signed(m_tdata[62:31]));
          fail_count++;
        end else begin
          want = expected_steps.pop_front();
          if (m_tdata[30:0] !== want.variance) begin
            $error("variance_out expected %0d actual %0d", want.variance, m_tdata[30:0]);
            fail_count++;
          end
          if (m_tdata[62:31] !== want.price) begin
            $error("price_out expected %0d actual %0d", $signed(want.price),
                   $signed(m_tdata[62:31]));
            fail_count++;
          end
          if (m_tlast !== want.done) begin
            $error("path_done expected %0d actual %0d", want.done, m_tlast);
            fail_count++;
          end
        end
      end
    end
  end

endmodule

`default_nettype wire

// ===== tb/sv/heston_euler_path_step_tb.sv =====
// ----------------------------------------------------------------------------
// heston_euler_path_step_tb
// Drives directed and random steps through the Heston Euler path step block
// under several register settings and idle patterns on both sides; the
// checker beside the block predicts and compares every result.
// ----------------------------------------------------------------------------
`default_nettype none

module heston_euler_path_step_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import hep_pkg::*;

  logic        clk;
  logic        rst;
  logic        s_tvalid;
  logic        s_tready;
  logic [87:0] s_tdata;    // time_increment, variance_noise, price_noise, zeros
  logic        m_tvalid;
  logic        m_tready;
  logic [63:0] m_tdata;    // variance_out, price_out, zero
  logic        m_tlast;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [3:0]  cfg_index;
  logic [31:0] cfg_data;
  int          fail_count;
  int          pending_steps;
  int          send_idle_pct;
  int          recv_idle_pct;

  heston_euler_path_step DUT (.*);

  heston_euler_path_step_checker path_checker (.*);

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Hard limit: 1155 items plus receiver stalls, many times over.
  initial begin
    #50ms;
    $display("CHECKS FAILED");
    $finish;
  end

  // Receiver with random stalls.
  always @(posedge clk) begin
    if (rst) m_tready <= 1'b0;
    else m_tready <= ($urandom_range(99) >= recv_idle_pct);
  end

  // One register write, after which the channel goes quiet.
  task automatic write_reg(logic [3:0] idx, logic [31:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  // The item stays valid after acceptance until the next idle cycle or item.
  task automatic send_step(logic [16:0] dt, logic [31:0] wv, logic [31:0] ws);
    while ($urandom_range(99) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {7'd0, ws, wv, dt};
    do @(posedge clk); while (!s_tready);
  endtask

  // Random step with mostly modest noise and step lengths, some extremes.
  task automatic send_random_step();
    logic [16:0] dt;
    logic [31:0] wv;
    logic [31:0] ws;
    case ($urandom_range(9))
      0: dt = 17'($urandom_range(131071));
      1: dt = 17'd65536;
      default: dt = 17'($urandom_range(6554));
    endcase
    wv = ($urandom_range(4) == 0) ? $urandom : 32'($signed($urandom_range(262144)) - 131072);
    ws = ($urandom_range(4) == 0) ? $urandom : 32'($signed($urandom_range(262144)) - 131072);
    send_step(dt, wv, ws);
  endtask

  task automatic drain();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (pending_steps != 0) @(posedge clk);
    repeat (100) @(posedge clk);
  endtask

  // A random register setting; extreme values mixed in.
  task automatic random_settings();
    write_reg(REG_REVERSION, ($urandom_range(3) == 0) ? 32'h7FFFFFFF : $urandom_range(196608));
    write_reg(REG_LONG_VAR, ($urandom_range(3) == 0) ? $urandom : $urandom_range(20000));
    write_reg(REG_VOL_VAR, ($urandom_range(3) == 0) ? $urandom : $urandom_range(65536));
    write_reg(REG_DRIFT, ($urandom_range(3) == 0) ? $urandom
                          : 32'($signed($urandom_range(20000)) - 10000));
    write_reg(REG_INIT_VAR, ($urandom_range(3) == 0) ? $urandom : $urandom_range(20000));
    write_reg(REG_INIT_PRC, ($urandom_range(3) == 0) ? $urandom : $urandom_range(13107200));
    write_reg(REG_PATH_LEN, ($urandom_range(3) == 0) ? $urandom : $urandom_range(40));
    write_reg(REG_MODE, $urandom);
  endtask

  initial begin
    rst = 1'b1;
    s_tvalid = 1'b0;
    s_tdata = '0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    m_tready = 1'b0;
    send_idle_pct = 0;
    recv_idle_pct = 0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: defaults, then field extremes and special cases.
    send_step(17'd655, 32'd0, 32'd0);
    send_step(17'd65536, 32'h7FFFFFFF, 32'h7FFFFFFF);
    send_step(17'h1FFFF, 32'h80000000, 32'h80000000);
    send_step(17'd0, 32'hFFFFFFFF, 32'h00000001);
    drain();
    // Initial values written mid-path apply only at the next path start.
    write_reg(REG_PATH_LEN, 32'd3);
    write_reg(REG_INIT_VAR, 32'h7FFFFFFF);
    write_reg(REG_INIT_PRC, 32'h80000000);
    write_reg(4'd9, 32'hFFFFFFFF);
    for (int i = 0; i < 5; i++) send_step(17'd65536, 32'h00010000, 32'hFFFF0000);
    drain();
    // Path length lowered mid-path, then zero, additive mode.
    write_reg(REG_PATH_LEN, 32'd1);
    write_reg(REG_MODE, 32'd1);
    write_reg(REG_REVERSION, 32'h7FFFFFFF);
    write_reg(REG_LONG_VAR, 32'h7FFFFFFF);
    write_reg(REG_VOL_VAR, 32'h7FFFFFFF);
    write_reg(REG_DRIFT, 32'h80000000);
    for (int i = 0; i < 3; i++) send_step(17'h1FFFF, 32'h7FFFFFFF, 32'h80000000);
    drain();
    write_reg(REG_PATH_LEN, 32'd0);
    write_reg(REG_REVERSION, 32'd0);
    write_reg(REG_LONG_VAR, 32'd0);
    write_reg(REG_VOL_VAR, 32'd0);
    write_reg(REG_DRIFT, 32'h7FFFFFFF);
    write_reg(REG_INIT_VAR, 32'd0);
    write_reg(REG_INIT_PRC, 32'h7FFFFFFF);
    write_reg(REG_MODE, 32'd0);
    for (int i = 0; i < 3; i++) send_step(17'd65536, 32'h80000000, 32'h7FFFFFFF);
    drain();

    // Random phases with changing idle patterns.
    for (int phase = 0; phase < 12; phase++) begin
      if (phase < 4) begin
        send_idle_pct = 20;
        recv_idle_pct = 59;
      end else if (phase < 8) begin
        send_idle_pct = 59;
        recv_idle_pct = 20;
      end else begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      random_settings();
      for (int i = 0; i < 95; i++) send_random_step();
      drain();
    end

    if (fail_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

`default_nettype wire
